// ===== rtl/prank_pkg.sv =====
// Shared widths, defaults and controller/datapath interface types for the permutation ranker.
package prank_pkg;

  localparam int ELEM_W       = 4;
  localparam int SIZE_W       = 5;
  localparam int RANK_W       = 45;
  localparam int VALUE_CNT    = 1 << ELEM_W;
  localparam int MIN_SIZE     = 2;
  localparam int DEF_MAX_SIZE = 16;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;     // an element transfer happens this cycle
    logic capture;  // load the result register with the finished rank
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;     // the element now presented completes the permutation
  } status_t;

endpackage

// ===== rtl/prank_datapath.sv =====
// Datapath: seen-value bitmap, position counter, Horner accumulator and result register.
module prank_datapath import prank_pkg::*; #(
  parameter int MAX_SIZE = DEF_MAX_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              perm_size_we_i,
  input  logic [SIZE_W-1:0] perm_size_i,
  input  logic [ELEM_W-1:0] element_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic [RANK_W-1:0] rank_o,
  output logic              status_bit_o
);

  // Element values never exceed VALUE_CNT-1, and sizes never exceed MAX_SIZE.
  localparam int SeenW = (MAX_SIZE < VALUE_CNT) ? MAX_SIZE : VALUE_CNT;
  localparam logic [SIZE_W-1:0] MaxSizeC = SIZE_W'(MAX_SIZE);
  localparam logic [SIZE_W-1:0] MinSizeC = SIZE_W'(MIN_SIZE);

  logic [SIZE_W-1:0] perm_size_q;
  logic [SeenW-1:0]  seen_q, seen_d;
  logic [SIZE_W-1:0] pos_q, pos_d;
  logic [RANK_W-1:0] acc_q, acc_d;
  logic              err_q, err_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic              stat_q, stat_d;

  logic [SIZE_W-1:0]        size_eff;
  logic [SIZE_W-1:0]        pos_eff;
  logic [SIZE_W-1:0]        pos_next;
  logic [SIZE_W-1:0]        factor;
  logic [VALUE_CNT-1:0]     seen_ext;
  logic [VALUE_CNT-1:0]     elem_bit;
  logic [VALUE_CNT-1:0]     below;
  logic [ELEM_W:0]          below_cnt;
  logic [ELEM_W-1:0]        digit;
  logic                     bad_elem;
  logic                     err_any;
  logic                     last;
  logic [RANK_W+SIZE_W-1:0] product;
  logic [RANK_W-1:0]        acc_new;

  // Balanced adder tree over the 16-bit mask.
  function automatic logic [ELEM_W:0] count_ones(input logic [VALUE_CNT-1:0] v);
    logic [1:0] l1 [8];
    logic [2:0] l2 [4];
    logic [3:0] l3 [2];
    for (int i = 0; i < 8; i++) begin
      l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    return {1'b0, l3[0]} + {1'b0, l3[1]};
  endfunction

  always_comb begin
    if (perm_size_q < MinSizeC) begin
      size_eff = MinSizeC;
    end else if (perm_size_q > MaxSizeC) begin
      size_eff = MaxSizeC;
    end else begin
      size_eff = perm_size_q;
    end

    pos_eff  = (pos_q >= size_eff) ? '0 : pos_q;
    pos_next = pos_eff + SIZE_W'(1);
    last     = (pos_next >= size_eff);
    factor   = size_eff - pos_eff;

    seen_ext  = VALUE_CNT'(seen_q);
    elem_bit  = VALUE_CNT'(1) << element_i;
    below     = seen_ext & (elem_bit - VALUE_CNT'(1));
    below_cnt = count_ones(below);
    digit     = ELEM_W'({1'b0, element_i} - below_cnt);

    bad_elem = ({1'b0, element_i} >= size_eff) || ((seen_ext & elem_bit) != '0);
    err_any  = err_q | bad_elem;

    product = acc_q * factor;
    acc_new = product[RANK_W-1:0] + RANK_W'(digit);

    seen_d = seen_q;
    pos_d  = pos_q;
    acc_d  = acc_q;
    err_d  = err_q;
    if (perm_size_we_i) begin
      seen_d = '0;
      pos_d  = '0;
      acc_d  = '0;
      err_d  = 1'b0;
    end else if (cmd_i.step) begin
      if (last) begin
        seen_d = '0;
        pos_d  = '0;
        acc_d  = '0;
        err_d  = 1'b0;
      end else begin
        pos_d = pos_next;
        err_d = err_any;
        if (!bad_elem) begin
          acc_d  = acc_new;
          seen_d = SeenW'(seen_ext | elem_bit);
        end
      end
    end

    // The finishing element may itself be bad, so the error is checked here too.
    rank_d = err_any ? '0 : (bad_elem ? acc_q : acc_new);
    stat_d = err_any;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      perm_size_q <= SIZE_RESET;
      seen_q      <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      err_q       <= 1'b0;
    end else begin
      if (perm_size_we_i) begin
        perm_size_q <= perm_size_i;
      end
      seen_q <= seen_d;
      pos_q  <= pos_d;
      acc_q  <= acc_d;
      err_q  <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rank_q <= rank_d;
      stat_q <= stat_d;
    end
  end

  assign status_o.last = last;
  assign rank_o        = rank_q;
  assign status_bit_o  = stat_q;

endmodule

// ===== rtl/prank_ctrl.sv =====
// Controller: element transfer control and result register occupancy state machine.
module prank_ctrl import prank_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    element_valid_i,
  output logic    element_stall_o,
  output logic    result_valid_o,
  input  logic    result_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_FULL  = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic full;
  logic step;
  logic capture;

  assign full            = (state_q == ST_FULL);
  // A new element may enter while the held result leaves in the same cycle.
  assign element_stall_o = full && result_stall_i;
  assign step            = element_valid_i && !element_stall_o;
  assign capture         = step && status_i.last;
  assign result_valid_o  = full;
  assign cmd_o.step      = step;
  assign cmd_o.capture   = capture;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_EMPTY: begin
        if (capture) begin
          state_d = ST_FULL;
        end
      end
      ST_FULL: begin
        if (!result_stall_i && !capture) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    element_stall_o |-> result_valid_o)
    else $error("element stall raised without a held result");

  a_capture_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |=> result_valid_o)
    else $error("finished permutation did not produce a result");

  a_taken_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_stall_i && !capture) |=> !result_valid_o)
    else $error("result repeated after its transfer");

endmodule

// ===== rtl/permutation_rank.sv =====
// Top level of the permutation ranker: controller plus datapath.
//
// Elements of a permutation arrive on the element channel (element_valid_i,
// element_stall_o, element_i), one per transfer, in position order. The size N
// is set through perm_size_we_i/perm_size_i; a write also restarts the current
// permutation. Sizes below 2 act as 2 and sizes above MAX_SIZE act as MAX_SIZE.
// After the N-th element the result channel (result_valid_o, result_stall_i,
// rank_o, status_o) carries the lexicographic rank and a status bit; a repeated
// or out-of-range element anywhere in the permutation gives status 1 and rank 0.
// The bitmap count and the 45x5 multiply-add of the Horner step sit in one
// stage, so one element is accepted per cycle unless element_stall_o holds it.
// The result is registered at the last element's transfer, appears in the next
// cycle and stays in the output register until taken. While a result is held
// and the receiver stalls, element_stall_o is high; when the result leaves, a
// new element can be accepted in the same cycle. Reset clears the accumulator,
// bitmap and position, empties the output register and sets the size to 16.
module permutation_rank import prank_pkg::*; #(
  parameter int MAX_SIZE = DEF_MAX_SIZE
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              perm_size_we_i,
  input  logic [SIZE_W-1:0] perm_size_i,
  input  logic              element_valid_i,
  output logic              element_stall_o,
  input  logic [ELEM_W-1:0] element_i,
  output logic              result_valid_o,
  input  logic              result_stall_i,
  output logic [RANK_W-1:0] rank_o,
  output logic              status_o
);

  cmd_t    cmd;
  status_t dp_status;

  prank_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .element_valid_i (element_valid_i),
    .element_stall_o (element_stall_o),
    .result_valid_o  (result_valid_o),
    .result_stall_i  (result_stall_i),
    .status_i        (dp_status),
    .cmd_o           (cmd)
  );

  prank_datapath #(
    .MAX_SIZE (MAX_SIZE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .perm_size_we_i (perm_size_we_i),
    .perm_size_i    (perm_size_i),
    .element_i      (element_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .rank_o         (rank_o),
    .status_bit_o   (status_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the permutation ranker with directed and random permutations.
module tb_top;
  import prank_pkg::*;

  localparam int MAX_N      = DEF_MAX_SIZE;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN      = 4;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              status;
  } rank_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              perm_size_we_i  = 1'b0;
  logic [SIZE_W-1:0] perm_size_i     = '0;
  logic              element_valid_i = 1'b0;
  logic              element_stall_o;
  logic [ELEM_W-1:0] element_i       = '0;
  logic              result_valid_o;
  logic              result_stall_i  = 1'b0;
  logic [RANK_W-1:0] rank_o;
  logic              status_o;

  always #2 clk_i = ~clk_i;

  permutation_rank #(.MAX_SIZE(MAX_N)) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .perm_size_we_i (perm_size_we_i),
    .perm_size_i    (perm_size_i),
    .element_valid_i(element_valid_i),
    .element_stall_o(element_stall_o),
    .element_i      (element_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .rank_o         (rank_o),
    .status_o       (status_o)
  );

  // Predictor state for the permutation in progress.
  logic [SIZE_W-1:0]    size_reg;
  logic [VALUE_CNT-1:0] seen_mask;
  int unsigned          next_pos;
  logic [RANK_W-1:0]    rank_acc;
  logic                 perm_bad;
  rank_result_t         rank_q[$];
  logic [ELEM_W-1:0]    perm_buf[VALUE_CNT];

  int   mismatches  = 0;
  int   idle_cycles = 0;
  bit   gaps_on     = 1'b1;
  bit   stall_on    = 1'b1;
  rank_result_t want;

  function automatic int unsigned active_size();
    if (size_reg < MIN_SIZE) return MIN_SIZE;
    if (size_reg > MAX_N) return MAX_N;
    return size_reg;
  endfunction

  function automatic void clear_perm();
    seen_mask = '0;
    next_pos  = 0;
    rank_acc  = '0;
    perm_bad  = 1'b0;
  endfunction

  // Horner step of the Lehmer code; queues the rank once the permutation is complete.
  function automatic void add_element(input logic [ELEM_W-1:0] e);
    int unsigned          n;
    int unsigned          digit;
    logic [63:0]          wide;
    logic [VALUE_CNT-1:0] below_mask;
    rank_result_t         res;
    n = active_size();
    if (next_pos >= n) next_pos = 0;
    if (e >= n || seen_mask[e]) begin
      perm_bad = 1'b1;
    end else begin
      below_mask = '1;
      below_mask = ~(below_mask << e);
      digit      = e - $countones(seen_mask & below_mask);
      wide       = 64'(rank_acc) * 64'(n - next_pos) + 64'(digit);
      rank_acc   = wide[RANK_W-1:0];
      seen_mask[e] = 1'b1;
    end
    next_pos++;
    if (next_pos >= n) begin
      res.rank   = perm_bad ? '0 : rank_acc;
      res.status = perm_bad;
      rank_q.insert(rank_q.size(), res);
      clear_perm();
    end
  endfunction

  task automatic send_element(input logic [ELEM_W-1:0] e);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      element_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    element_i       <= e;
    element_valid_i <= 1'b1;
    do @(posedge clk_i); while (element_stall_o);
    add_element(e);
  endtask

  task automatic wait_drained();
    while (rank_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_perm_size(input int unsigned v);
    element_valid_i <= 1'b0;
    wait_drained();
    perm_size_i    <= v[SIZE_W-1:0];
    perm_size_we_i <= 1'b1;
    @(posedge clk_i);
    perm_size_we_i <= 1'b0;
    size_reg = v[SIZE_W-1:0];
    clear_perm();
  endtask

  // Fills perm_buf with a shuffled permutation of 0..n-1, optionally with one bad element.
  task automatic make_perm(input int unsigned n, input bit broken);
    int unsigned j;
    int unsigned p;
    logic [ELEM_W-1:0] tmp;
    for (int i = 0; i < n; i++) perm_buf[i] = ELEM_W'(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm_buf[i];
      perm_buf[i] = perm_buf[j];
      perm_buf[j] = tmp;
    end
    if (broken) begin
      p = $urandom_range(0, n - 1);
      if (n < VALUE_CNT && $urandom_range(0, 1)) begin
        perm_buf[p] = ELEM_W'($urandom_range(n, VALUE_CNT - 1));
      end else begin
        j = (p + $urandom_range(1, n - 1)) % n;
        perm_buf[p] = perm_buf[j];
      end
    end
  endtask

  task automatic send_prefix(input int unsigned count);
    for (int i = 0; i < count; i++) send_element(perm_buf[i]);
  endtask

  // Mostly well-formed permutations, some with one bad element, some pure noise.
  task automatic run_phase(input int unsigned size_val, input int unsigned items);
    int unsigned n;
    int unsigned sent;
    int unsigned kind;
    write_perm_size(size_val);
    n    = active_size();
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        for (int i = 0; i < n; i++) perm_buf[i] = ELEM_W'($urandom_range(0, VALUE_CNT - 1));
      end else begin
        make_perm(n, kind < 6);
      end
      send_prefix(n);
      sent += n;
    end
    // A partial permutation left here is restarted by the next size write.
    if ($urandom_range(0, 1)) begin
      make_perm(n, 1'b0);
      send_prefix($urandom_range(1, n - 1));
    end
  endtask

  task automatic test_max_rank();
    for (int i = MAX_N - 1; i >= 0; i--) send_element(ELEM_W'(i));
  endtask

  task automatic test_size_two();
    write_perm_size(2);
    send_element(0);
    send_element(1);
    send_element(1);
    send_element(0);
  endtask

  task automatic test_bad_elements();
    write_perm_size(3);
    send_element(1);
    send_element(1);
    send_element(0);
    // The last element is out of range.
    send_element(0);
    send_element(1);
    send_element(3);
  endtask

  task automatic test_random_sizes();
    for (int s = 0; s <= MAX_N + 1; s++) run_phase(s, 16);
    run_phase(31, 16);
    run_phase($urandom_range(0, 31), 16);
    run_phase($urandom_range(0, 31), 16);
  endtask

  task automatic test_no_idle();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    run_phase($urandom_range(0, 31), 60);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        result_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        result_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (rank_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: rank %0d status %0d", rank_o, status_o);
      end else begin
        want = rank_q.pop_front();
        if (rank_o !== want.rank || status_o !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected rank %0d status %0d, got rank %0d status %0d",
                     want.rank, want.status, rank_o, status_o);
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || perm_size_we_i || (element_valid_i && !element_stall_o) ||
        (result_valid_o && !result_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[permutation_rank] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    size_reg = SIZE_RESET;
    clear_perm();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_max_rank();
    test_size_two();
    test_bad_elements();
    test_random_sizes();
    test_no_idle();
    element_valid_i <= 1'b0;
    wait_drained();
    if (mismatches == 0 && rank_q.size() == 0) begin
      $display("[permutation_rank] OK");
    end else begin
      $display("[permutation_rank] ERROR");
    end
    $finish;
  end

endmodule
